>>> rtl/hmmc_pkg.sv
// ----------------------------------------------------------------------------
// hmmc_pkg: shared types and codes
// Operation codes, register indexes and the command record that sits in the
// front queue of the hashed message match counter.
// ----------------------------------------------------------------------------
`default_nettype none

package hmmc_pkg;

  localparam int MAX_MESSAGES_DEF = 4096;
  localparam int WORD_BITS_DEF    = 32;
  localparam int FIELD_BITS       = 32;
  localparam int COUNT_BITS       = 13;

  localparam logic [1:0] FUNC_STORE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_BUCKETS = 1'b1;

  localparam logic [FIELD_BITS-1:0] MODULUS_RST = 32'd3;
  localparam logic [FIELD_BITS-1:0] BUCKETS_RST = 32'd1;

  typedef struct packed {
    logic [1:0]            func;
    logic [FIELD_BITS-1:0] coef_mul;
    logic [FIELD_BITS-1:0] coef_add;
    logic [FIELD_BITS-1:0] bucket_tag;
    logic [FIELD_BITS-1:0] query_ident;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] modulus;
    logic [FIELD_BITS-1:0] buckets;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/hashed_message_match_counter.sv
// ----------------------------------------------------------------------------
// hashed_message_match_counter: top level
// Message store with hashed match counting over all stored messages.
//
//   channel   signals                                         handshake
//   items     start, func, coef_mul, coef_add, bucket_tag,     start && !busy
//             query_ident
//   results   done, match_count, overflow                      done, one cycle
//   config    cfg_we, cfg_index, cfg_data                      cfg_we
//
// store, clear and unused codes give their result once at the queue head in idle.
// a query visits each stored message in turn through the bit-serial remainder
// unit, run twice per entry; a zero modulus or bucket count passes the value
// of its pass through unreduced.
// a two-entry queue takes items while the back end works; busy is queue full.
// reset clears the queue, the message count and the result strobe; no ram sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_message_match_counter #(
  parameter int MAX_MESSAGES = hmmc_pkg::MAX_MESSAGES_DEF,
  parameter int WORD_BITS    = hmmc_pkg::WORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      func,
  input  wire logic [hmmc_pkg::FIELD_BITS-1:0] coef_mul,
  input  wire logic [hmmc_pkg::FIELD_BITS-1:0] coef_add,
  input  wire logic [hmmc_pkg::FIELD_BITS-1:0] bucket_tag,
  input  wire logic [hmmc_pkg::FIELD_BITS-1:0] query_ident,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [hmmc_pkg::FIELD_BITS-1:0] cfg_data,
  output logic                                 done,
  output logic      [hmmc_pkg::COUNT_BITS-1:0] match_count,
  output logic                                 overflow
);
  import hmmc_pkg::*;

  cfg_t cfg;
  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic pop;
  logic full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus <= MODULUS_RST;
      cfg.buckets <= BUCKETS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS: cfg.modulus <= cfg_data;
        CFG_BUCKETS: cfg.buckets <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_cmd.func        = func;
    in_cmd.coef_mul    = coef_mul;
    in_cmd.coef_add    = coef_add;
    in_cmd.bucket_tag  = bucket_tag;
    in_cmd.query_ident = query_ident;
  end

  assign busy = full;

  hmmc_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (start && !full),
    .in_cmd  (in_cmd),
    .full    (full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop)
  );

  hmmc_back #(
    .MAX_MESSAGES (MAX_MESSAGES),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .done        (done),
    .match_count (match_count),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire

>>> rtl/hmmc_ram.sv
// ----------------------------------------------------------------------------
// hmmc_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/hmmc_front.sv
// ----------------------------------------------------------------------------
// hmmc_front: command intake
// Accepts items, masks words to the word width and queues them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmc_front #(
  parameter int WORD_BITS = hmmc_pkg::WORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire hmmc_pkg::cmd_t in_cmd,
  output logic               full,
  output logic               q_valid,
  output hmmc_pkg::cmd_t     q_cmd,
  input  wire logic          pop
);
  import hmmc_pkg::*;

  localparam logic [FIELD_BITS-1:0] WMASK = FIELD_BITS'((64'd1 << WORD_BITS) - 64'd1);

  cmd_t       slot [2];
  cmd_t       masked;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_comb begin
    masked             = in_cmd;
    masked.coef_mul    = in_cmd.coef_mul & WMASK;
    masked.coef_add    = in_cmd.coef_add & WMASK;
    masked.bucket_tag  = in_cmd.bucket_tag & WMASK;
    masked.query_ident = in_cmd.query_ident & WMASK;
  end

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= masked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/hmmc_modred.sv
// ----------------------------------------------------------------------------
// hmmc_modred: bit-serial remainder unit
// Reduces a wide value by a 32-bit modulus, one dividend bit per cycle.
// A zero modulus passes the value through.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmc_modred #(
  parameter int DW = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            go,
  input  wire logic [DW-1:0]                   x,
  input  wire logic [hmmc_pkg::FIELD_BITS-1:0] m,
  output logic                                 done,
  output logic      [DW-1:0]                   rem
);
  import hmmc_pkg::*;

  localparam int CW = (DW + 1 > FIELD_BITS + 1) ? DW + 1 : FIELD_BITS + 1;
  localparam int SW = $clog2(DW);

  logic [DW-1:0]         xs;
  logic [FIELD_BITS-1:0] mreg;
  logic [SW-1:0]         cnt;
  logic                  run;
  logic [CW-1:0]         rem_sh;
  logic [CW-1:0]         diff;
  logic                  ge;

  always_comb begin
    rem_sh = (CW)'({rem, xs[DW-1]});
    diff   = rem_sh - CW'(mreg);
    ge     = (rem_sh >= CW'(mreg));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        if (m == '0) begin
          rem  <= x;
          done <= 1'b1;
        end else begin
          xs   <= x;
          mreg <= m;
          rem  <= '0;
          cnt  <= '0;
          run  <= 1'b1;
        end
      end else if (run) begin
        rem <= ge ? DW'(diff) : DW'(rem_sh);
        xs  <= {xs[DW-2:0], 1'b0};
        cnt <= cnt + SW'(1);
        if (cnt == SW'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/hmmc_back.sv
// ----------------------------------------------------------------------------
// hmmc_back: command execution
// Stores, clears and runs queries over the message ram, one entry at a time
// through a multiplier and two passes of the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmc_back #(
  parameter int MAX_MESSAGES = hmmc_pkg::MAX_MESSAGES_DEF,
  parameter int WORD_BITS    = hmmc_pkg::WORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hmmc_pkg::cfg_t                  cfg,
  input  wire logic                            q_valid,
  input  wire hmmc_pkg::cmd_t                  q_cmd,
  output logic                                 pop,
  output logic                                 done,
  output logic      [hmmc_pkg::COUNT_BITS-1:0] match_count,
  output logic                                 overflow
);
  import hmmc_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = 2 * W;
  localparam int AW = $clog2(MAX_MESSAGES);
  localparam int TW = $clog2(MAX_MESSAGES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_RED1 = 3'd3;
  localparam logic [2:0] ST_RED2 = 3'd4;

  logic [2:0]            state;
  logic [TW-1:0]         total;
  logic [TW-1:0]         k;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [W-1:0]          id;
  logic [W-1:0]          vreg;
  logic [W-1:0]          wreg;
  logic [DW-1:0]         prod;
  logic                  full;
  logic                  last;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [3*W-1:0]        ram_wdata;
  logic [3*W-1:0]        ram_rdata;
  logic                  red_go;
  logic [DW-1:0]         red_x;
  logic [FIELD_BITS-1:0] red_m;
  logic                  red_done;
  logic [DW-1:0]         red_rem;

  always_comb begin
    full       = (total >= TW'(MAX_MESSAGES));
    last       = ((k + TW'(1)) == total);
    pop        = (state == ST_IDLE) && q_valid;
    ram_we     = pop && (q_cmd.func == FUNC_STORE) && !full;
    ram_wdata  = {q_cmd.coef_mul[W-1:0], q_cmd.coef_add[W-1:0], q_cmd.bucket_tag[W-1:0]};
    ram_re     = (pop && (q_cmd.func == FUNC_QUERY) && (total != '0)) ||
                 ((state == ST_RED2) && red_done && !last);
    ram_raddr  = (state == ST_IDLE) ? '0 : AW'(k + TW'(1));
    red_go     = (state == ST_SUM) || ((state == ST_RED1) && red_done);
    red_x      = (state == ST_SUM) ? (prod + DW'(vreg)) : red_rem;
    red_m      = (state == ST_SUM) ? cfg.modulus : cfg.buckets;
    count_next = count + COUNT_BITS'(red_rem == DW'(wreg));
  end

  hmmc_ram #(
    .WIDTH (3 * W),
    .DEPTH (MAX_MESSAGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hmmc_modred #(
    .DW (DW)
  ) u_modred (
    .clk  (clk),
    .rst  (rst),
    .go   (red_go),
    .x    (red_x),
    .m    (red_m),
    .done (red_done),
    .rem  (red_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            match_count <= '0;
            overflow    <= 1'b0;
            unique case (q_cmd.func)
              FUNC_STORE: begin
                done <= 1'b1;
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  total <= total + TW'(1);
                end
              end
              FUNC_QUERY: begin
                if (total == '0) begin
                  done <= 1'b1;
                end else begin
                  id    <= q_cmd.query_ident[W-1:0];
                  k     <= '0;
                  count <= '0;
                  state <= ST_LOAD;
                end
              end
              FUNC_CLEAR: begin
                total <= '0;
                done  <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_LOAD: begin
          prod  <= DW'(ram_rdata[3*W-1:2*W]) * DW'(id);
          vreg  <= ram_rdata[2*W-1:W];
          wreg  <= ram_rdata[W-1:0];
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_RED1;
        end
        ST_RED1: begin
          if (red_done) begin
            state <= ST_RED2;
          end
        end
        ST_RED2: begin
          if (red_done) begin
            count <= count_next;
            if (last) begin
              match_count <= count_next;
              overflow    <= 1'b0;
              done        <= 1'b1;
              state       <= ST_IDLE;
            end else begin
              k     <= k + TW'(1);
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/hmmc_checker.sv
// ----------------------------------------------------------------------------
// hmmc_checker: port-level checks
// Watches the top level's ports and flags behavior the block must not show.
// ----------------------------------------------------------------------------
`default_nettype none

module hmmc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic [hmmc_pkg::COUNT_BITS-1:0] match_count,
  input wire logic                            overflow
);

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result or busy right after reset");

  a_overflow_zero_count: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (match_count == '0))
    else $error("overflow item carries a count");

  a_busy_needs_item: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("queue filled without an accepted item");

endmodule

bind hashed_message_match_counter hmmc_checker u_hmmc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .match_count (match_count),
  .overflow    (overflow)
);

`default_nettype wire
